// File: hw/rtl/tsm_pkg.sv
// Shared constants for the triangle stiffness matrix block.
`default_nettype none
package tsm_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int Q_BITS         = 32;
  localparam int META_W         = 6;
  localparam int QUEUE_DEPTH    = 4;
  localparam int ROW_W          = 2;
  localparam int OUT_TDATA_W    = 40;
  localparam int OUT_TUSER_W    = 2;
  localparam logic [Q_BITS-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_BITS-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [ROW_W-1:0]  IDX_LAST = 2'd2;
endpackage
`default_nettype wire

// File: hw/rtl/tsm_front.sv
// Front end: takes vertices, forms edge differences and twice the area, classifies.
`default_nettype none
module tsm_front import tsm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int C  = COORD_BITS,
  localparam int DW = 2*C+3,
  localparam int EW = 1 + DW + 6*(C+1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [6*C-1:0] in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [EW-1:0]      out_data
);
  logic ce;
  logic v1, v2, v3;
  logic signed [C-1:0] x0, y0, x1, y1, x2, y2;
  logic signed [C:0] dx1, dy2, dx2, dy1, b0, b2, c0, c1;
  logic signed [C:0] r_dx1, r_dy2, r_dx2, r_dy1, r_b0, r_b1, r_b2, r_c0, r_c1, r_c2;
  logic signed [C:0] s_b0, s_b1, s_b2, s_c0, s_c1, s_c2;
  logic signed [2*C+1:0] p1, p2;
  logic signed [2*C+2:0] a2;
  logic [DW-1:0] den;
  logic bad;

  // Stall the whole front when the queue cannot take the finished item
  assign ce        = !v3 || out_ready;
  assign in_ready  = ce;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Capture coordinates
  always_ff @(posedge clk) begin
    if (ce) begin
      x0 <= $signed(in_data[0*C +: C]);
      y0 <= $signed(in_data[1*C +: C]);
      x1 <= $signed(in_data[2*C +: C]);
      y1 <= $signed(in_data[3*C +: C]);
      x2 <= $signed(in_data[4*C +: C]);
      y2 <= $signed(in_data[5*C +: C]);
    end
  end

  // Edge differences
  assign dx1 = x1 - x0;
  assign dy2 = y2 - y0;
  assign dx2 = x2 - x0;
  assign dy1 = y1 - y0;
  assign b0  = y1 - y2;
  assign b2  = y0 - y1;
  assign c0  = x2 - x1;
  assign c1  = x0 - x2;

  always_ff @(posedge clk) begin
    if (ce) begin
      r_dx1 <= dx1;
      r_dy2 <= dy2;
      r_dx2 <= dx2;
      r_dy1 <= dy1;
      r_b0  <= b0;
      r_b1  <= dy2;
      r_b2  <= b2;
      r_c0  <= c0;
      r_c1  <= c1;
      r_c2  <= dx1;
    end
  end

  // Area cross products
  always_ff @(posedge clk) begin
    if (ce) begin
      p1   <= r_dx1 * r_dy2;
      p2   <= r_dx2 * r_dy1;
      s_b0 <= r_b0;
      s_b1 <= r_b1;
      s_b2 <= r_b2;
      s_c0 <= r_c0;
      s_c1 <= r_c1;
      s_c2 <= r_c2;
    end
  end

  // Twice the area, its double as divisor, and the bad-area flag
  assign a2  = p1 - p2;
  assign den = {a2[2*C+1:0], 1'b0};
  assign bad = a2[2*C+2] || (a2 == '0);

  assign out_data = {bad, den, s_c2, s_c1, s_c0, s_b2, s_b1, s_b0};
endmodule
`default_nettype wire

// File: hw/rtl/tsm_queue.sv
// Small FIFO between the front end and the entry back end.
`default_nettype none
module tsm_queue import tsm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0] count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/tsm_div.sv
// Pipelined restoring divider: one quotient bit per stage, with overflow check.
`default_nettype none
module tsm_div import tsm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DW = 2*COORD_BITS+3,
  localparam int W  = DW + Q_BITS + 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              ce,
  input  wire logic              in_valid,
  input  wire logic [W-1:0]      in_num,
  input  wire logic [DW-1:0]     in_den,
  input  wire logic              in_neg,
  input  wire logic [META_W-1:0] in_meta,
  output logic                   out_valid,
  output logic [Q_BITS-1:0]      out_q,
  output logic                   out_sat,
  output logic                   out_neg,
  output logic [META_W-1:0]      out_meta
);
  logic              v    [0:Q_BITS];
  logic [W-1:0]      r    [0:Q_BITS];
  logic [DW-1:0]     d    [0:Q_BITS];
  logic [Q_BITS-1:0] q    [0:Q_BITS];
  logic              sat  [0:Q_BITS];
  logic              ng   [0:Q_BITS];
  logic [META_W-1:0] meta [0:Q_BITS];

  // Load the first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (ce) begin
      v[0] <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      r[0]    <= in_num;
      d[0]    <= in_den;
      q[0]    <= '0;
      sat[0]  <= 1'b0;
      ng[0]   <= in_neg;
      meta[0] <= in_meta;
    end
  end

  // One trial subtract per stage, most significant quotient bit first
  for (genvar s = 0; s < Q_BITS; s++) begin : g_stage
    localparam int BIT = Q_BITS-1-s;
    logic [W-1:0] dsh;
    logic ge;
    logic ovf;
    assign dsh = W'(d[s]) << BIT;
    assign ge  = (r[s] >= dsh);
    assign ovf = (s == 0) ? (r[s] >= (W'(d[s]) << Q_BITS)) : sat[s];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (ce) begin
        v[s+1] <= v[s];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        r[s+1]    <= ge ? (r[s] - dsh) : r[s];
        q[s+1]    <= q[s] | ({{(Q_BITS-1){1'b0}}, ge} << BIT);
        d[s+1]    <= d[s];
        sat[s+1]  <= ovf;
        ng[s+1]   <= ng[s];
        meta[s+1] <= meta[s];
      end
    end
  end

  assign out_valid = v[Q_BITS];
  assign out_q     = q[Q_BITS];
  assign out_sat   = sat[Q_BITS];
  assign out_neg   = ng[Q_BITS];
  assign out_meta  = meta[Q_BITS];
endmodule
`default_nettype wire

// File: hw/rtl/tsm_back.sv
// Back end: walks the nine entries, forms numerators, divides, clips, drives results.
`default_nettype none
module tsm_back import tsm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int C  = COORD_BITS,
  localparam int DW = 2*C+3,
  localparam int EW = 1 + DW + 6*(C+1),
  localparam int W  = DW + Q_BITS + 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire logic [EW-1:0]     q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ROW_W-1:0]       out_row,
  output logic [ROW_W-1:0]       out_col,
  output logic [Q_BITS-1:0]      out_value,
  output logic                   out_clip,
  output logic                   out_bad,
  output logic                   out_last
);
  logic ce;
  logic signed [C:0] hb [0:2];
  logic signed [C:0] hc [0:2];
  logic [DW-1:0] h_den;
  logic h_bad;
  logic [ROW_W-1:0] row, col;
  logic issue_last;

  logic v1, v2;
  logic signed [C:0] bi, bj, ci, cj;
  logic [DW-1:0] den1, den2;
  logic [META_W-1:0] meta1, meta2;
  logic signed [2*C+1:0] pb, pc;
  logic signed [2*C+2:0] num;
  logic [2*C+2:0] mag;
  logic num_neg;
  logic [W-1:0] num_sh;

  logic d_valid, d_sat, d_neg;
  logic [Q_BITS-1:0] d_q;
  logic [META_W-1:0] d_meta;
  logic [Q_BITS-1:0] val;
  logic clip;

  // One global advance: stall everything while the result waits
  assign ce = !out_valid || out_ready;

  // Unpack the queue head
  assign hb[0] = $signed(q_data[0*(C+1) +: C+1]);
  assign hb[1] = $signed(q_data[1*(C+1) +: C+1]);
  assign hb[2] = $signed(q_data[2*(C+1) +: C+1]);
  assign hc[0] = $signed(q_data[3*(C+1) +: C+1]);
  assign hc[1] = $signed(q_data[4*(C+1) +: C+1]);
  assign hc[2] = $signed(q_data[5*(C+1) +: C+1]);
  assign h_den = q_data[6*(C+1) +: DW];
  assign h_bad = q_data[EW-1];

  assign issue_last = h_bad || (row == IDX_LAST && col == IDX_LAST);
  assign q_pop      = ce && q_valid && issue_last;

  // Step row and column through the matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (ce && q_valid) begin
      if (issue_last) begin
        row <= '0;
        col <= '0;
      end else if (col == IDX_LAST) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (ce) begin
      v1 <= q_valid;
      v2 <= v1;
    end
  end

  // Select operands of this entry
  always_ff @(posedge clk) begin
    if (ce) begin
      bi    <= hb[row];
      bj    <= hb[col];
      ci    <= hc[row];
      cj    <= hc[col];
      den1  <= h_den;
      meta1 <= h_bad ? {2'd0, 2'd0, 1'b1, 1'b1} : {row, col, 1'b0, issue_last};
    end
  end

  // Products
  always_ff @(posedge clk) begin
    if (ce) begin
      pb    <= bi * bj;
      pc    <= ci * cj;
      den2  <= den1;
      meta2 <= meta1;
    end
  end

  // Numerator, its magnitude and fraction scaling
  assign num     = pb + pc;
  assign num_neg = num[2*C+2];
  assign mag     = num_neg ? (2*C+3)'(-num) : (2*C+3)'(num);
  assign num_sh  = W'(mag) << FRAC_BITS;

  tsm_div #(.COORD_BITS(C)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (v2),
    .in_num   (num_sh),
    .in_den   (den2),
    .in_neg   (num_neg),
    .in_meta  (meta2),
    .out_valid(d_valid),
    .out_q    (d_q),
    .out_sat  (d_sat),
    .out_neg  (d_neg),
    .out_meta (d_meta)
  );

  // Saturate and restore the sign; a bad-area result is forced to zero
  always_comb begin
    val  = d_q;
    clip = 1'b0;
    if (d_meta[1]) begin
      val = '0;
    end else if (!d_neg) begin
      if (d_sat || d_q > VAL_MAX) begin
        val  = VAL_MAX;
        clip = 1'b1;
      end
    end else begin
      if (d_sat || d_q > VAL_MIN) begin
        val  = VAL_MIN;
        clip = 1'b1;
      end else begin
        val = -d_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= d_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      out_row   <= d_meta[5:4];
      out_col   <= d_meta[3:2];
      out_bad   <= d_meta[1];
      out_last  <= d_meta[0];
      out_value <= val;
      out_clip  <= clip;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/triangle_stiffness_matrix_top.sv
// Top level of the linear triangle stiffness matrix block.
`default_nettype none
// Takes one triangle per item (three vertices, signed COORD_BITS coordinates) and
// returns the nine entries (b_i*b_j + c_i*c_j)/(4*area) in row-major order, each a
// signed 32-bit value with FRAC_BITS fraction bits, truncated toward zero and
// saturated (tuser bit 0 set when clipped); tlast marks the ninth entry. A triangle
// of zero or negative signed area gives a single result with value 0, tuser bit 1
// set and tlast high. The result channel carries one entry per cycle while
// m_axis_tready stays high (the whole back end stalls otherwise); a four-deep
// queue between the area front end and the entry back end lets the next
// triangle be taken while entries still stream out.
module triangle_stiffness_matrix_top import tsm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int IN_TDATA_W = ((6*COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y, zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // row_index[1:0], col_index[3:2], entry_value[35:4], zero fill
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // clipped[0], bad_area[1]
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
  output logic                        m_axis_tlast
);
  localparam int C  = COORD_BITS;
  localparam int DW = 2*C+3;
  localparam int EW = 1 + DW + 6*(C+1);

  logic f_valid, q_full, q_valid, q_pop, f_push;
  logic [EW-1:0] f_data, q_head;
  logic [ROW_W-1:0] row, col;
  logic [Q_BITS-1:0] value;
  logic clip, bad, last;

  tsm_front #(.COORD_BITS(C)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata[6*C-1:0]),
    .out_valid(f_valid),
    .out_ready(!q_full),
    .out_data (f_data)
  );

  assign f_push = f_valid && !q_full;

  tsm_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .push_data(f_data),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head     (q_head)
  );

  tsm_back #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_head),
    .q_pop    (q_pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_row  (row),
    .out_col  (col),
    .out_value(value),
    .out_clip (clip),
    .out_bad  (bad),
    .out_last (last)
  );

  assign m_axis_tdata = {4'd0, value, col, row};
  assign m_axis_tuser = {bad, clip};
  assign m_axis_tlast = last;
endmodule
`default_nettype wire
